@@ src/awse_pkg.sv @@
// Shared types and constants for the adaptive window speed estimator.
package awse_pkg;

    localparam int unsigned POS_W_DEF   = 32;
    localparam int unsigned COUNT_W_DEF = 16;
    localparam int unsigned CFG_W       = 16;
    localparam int unsigned RATE_W      = 16;
    localparam int unsigned IN_W        = 32;
    localparam int unsigned SPEED_W     = 32;
    localparam int unsigned CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MOVE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE      = 2'd2;

    localparam logic [CFG_W-1:0] MOVE_THRESHOLD_RST = 16'd81;
    localparam logic [CFG_W-1:0] WINDOW_LIMIT_RST   = 16'd250;
    localparam logic [CFG_W-1:0] TICK_RATE_RST      = 16'd20000;

    localparam logic [SPEED_W-1:0] SPEED_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [SPEED_W-1:0] SPEED_NEG_MAX = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } awse_state_t;

endpackage

@@ src/awse_mul.sv @@
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module awse_mul #(
    parameter int unsigned A_WIDTH = awse_pkg::POS_W_DEF,
    parameter int unsigned B_WIDTH = awse_pkg::RATE_W
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [A_WIDTH-1:0]         op_a,
    input  logic [B_WIDTH-1:0]         op_b,
    output logic                       done,
    output logic [A_WIDTH+B_WIDTH-1:0] product
);
    import awse_pkg::*;

    localparam int unsigned P_W   = A_WIDTH + B_WIDTH;
    localparam int unsigned CNT_W = (B_WIDTH > 1) ? $clog2(B_WIDTH) : 1;

    logic [P_W-1:0]     a_reg, a_next;
    logic [B_WIDTH-1:0] b_reg, b_next;
    logic [P_W-1:0]     acc_reg, acc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               last_step;

    assign last_step = (cnt_reg == CNT_W'(B_WIDTH - 1));

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next    = P_W'(op_a);
            b_next    = op_b;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = {a_reg[P_W-2:0], 1'b0};
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg + CNT_W'(1);
            if (last_step) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ src/awse_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
module awse_div #(
    parameter int unsigned DVD_WIDTH = awse_pkg::POS_W_DEF + awse_pkg::RATE_W,
    parameter int unsigned DVS_WIDTH = awse_pkg::COUNT_W_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DVD_WIDTH-1:0] dividend,
    input  logic [DVS_WIDTH-1:0] divisor,
    output logic                 done,
    output logic [DVD_WIDTH-1:0] quotient
);
    import awse_pkg::*;

    localparam int unsigned CNT_W = $clog2(DVD_WIDTH);

    logic [DVD_WIDTH-1:0] dvd_reg, dvd_next;
    logic [DVS_WIDTH-1:0] dvs_reg, dvs_next;
    logic [DVS_WIDTH-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DVS_WIDTH:0]   trial;
    logic [DVS_WIDTH:0]   trial_sub;
    logic                 ge;
    logic                 last_step;

    assign trial     = {rem_reg, dvd_reg[DVD_WIDTH-1]};
    assign ge        = (trial >= {1'b0, dvs_reg});
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign last_step = (cnt_reg == CNT_W'(DVD_WIDTH - 1));

    always_comb begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? trial_sub[DVS_WIDTH-1:0] : trial[DVS_WIDTH-1:0];
            dvd_next = {dvd_reg[DVD_WIDTH-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (last_step) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

@@ src/adaptive_window_speed_estimator_unit.sv @@
// Top level of the adaptive window speed estimator.
// A sample that keeps the window open is registered, evaluated in ST_EVAL and its result
// loaded into the output register once the output is free. A sample that triggers a
// measurement runs through the bit-serial multiplier (ST_MUL), then the divider (ST_DIV).
// One sample is processed at a time; a finished result may wait while the next is taken.
// Synchronous active-low reset restores the register defaults, a zero reference and held speed.
module adaptive_window_speed_estimator_unit #(
    parameter int unsigned POS_WIDTH   = awse_pkg::POS_W_DEF,
    parameter int unsigned COUNT_WIDTH = awse_pkg::COUNT_W_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [awse_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [awse_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [awse_pkg::IN_W-1:0]    s_position,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [awse_pkg::SPEED_W-1:0] m_speed,
    output logic                                m_refreshed
);
    import awse_pkg::*;

    localparam int unsigned PROD_W = POS_WIDTH + RATE_W;
    localparam int unsigned EXT_W  = (POS_WIDTH > IN_W) ? POS_WIDTH : IN_W;
    localparam int unsigned CMP_W  = (COUNT_WIDTH + 1 > CFG_W) ? COUNT_WIDTH + 1 : CFG_W;

    awse_state_t state_reg, state_next;

    logic [CFG_W-1:0]       thr_reg, win_reg, rate_reg;
    logic [POS_WIDTH-1:0]   pos_reg, diff_reg, ref_reg;
    logic [COUNT_WIDTH-1:0] tick_count_reg;
    logic [COUNT_WIDTH-1:0] div_count_reg;
    logic [SPEED_W-1:0]     held_speed_reg;
    logic                   neg_reg;
    logic                   m_valid_reg;
    logic [SPEED_W-1:0]     m_speed_reg;
    logic                   m_refreshed_reg;

    logic signed [EXT_W-1:0] pos_wide;
    logic [POS_WIDTH-1:0]    pos_ext;
    logic [POS_WIDTH-1:0]    mag;
    logic [COUNT_WIDTH:0]    count_inc;
    logic                    window_hit;
    logic                    fire;
    logic                    out_free;
    logic [SPEED_W-1:0]      sat_speed;

    logic                    take_in;
    logic                    mul_start;
    logic                    div_start;
    logic                    keep_load;
    logic                    meas_load;
    logic                    mul_done;
    logic                    div_done;
    logic [PROD_W-1:0]       product;
    logic [PROD_W-1:0]       quotient;

    assign pos_wide = EXT_W'(s_position);
    assign pos_ext  = pos_wide[POS_WIDTH-1:0];

    assign mag        = diff_reg[POS_WIDTH-1] ? ((~diff_reg) + POS_WIDTH'(1)) : diff_reg;
    assign count_inc  = {1'b0, tick_count_reg} + (COUNT_WIDTH + 1)'(1);
    assign window_hit = CMP_W'(count_inc) > CMP_W'(win_reg);
    assign fire       = (mag > POS_WIDTH'(thr_reg)) || count_inc[COUNT_WIDTH] || window_hit;
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        if (neg_reg) begin
            sat_speed = (quotient > PROD_W'(SPEED_NEG_MAX)) ? SPEED_NEG_MAX
                                                            : SPEED_W'(0) - quotient[SPEED_W-1:0];
        end else begin
            sat_speed = (quotient > PROD_W'(SPEED_POS_MAX)) ? SPEED_POS_MAX
                                                            : quotient[SPEED_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (fire) begin
                    state_next = ST_MUL;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        take_in   = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        keep_load = 1'b0;
        meas_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                take_in = s_valid;
            end
            ST_EVAL: begin
                mul_start = fire;
                keep_load = !fire && out_free;
            end
            ST_MUL: begin
                div_start = mul_done;
            end
            ST_DIV: begin
            end
            ST_DONE: begin
                meas_load = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            thr_reg        <= MOVE_THRESHOLD_RST;
            win_reg        <= WINDOW_LIMIT_RST;
            rate_reg       <= TICK_RATE_RST;
            ref_reg        <= '0;
            tick_count_reg <= COUNT_WIDTH'(1);
            held_speed_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_MOVE_THRESHOLD: thr_reg  <= cfg_wdata;
                    REG_WINDOW_LIMIT:   win_reg  <= cfg_wdata;
                    REG_TICK_RATE:      rate_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (mul_start) begin
                ref_reg        <= pos_reg;
                tick_count_reg <= COUNT_WIDTH'(1);
            end else if (keep_load) begin
                tick_count_reg <= count_inc[COUNT_WIDTH-1:0];
            end
            if (meas_load) begin
                held_speed_reg <= sat_speed;
            end
            if (keep_load || meas_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (take_in) begin
            pos_reg  <= pos_ext;
            diff_reg <= pos_ext - ref_reg;
        end
        if (mul_start) begin
            neg_reg       <= diff_reg[POS_WIDTH-1];
            div_count_reg <= tick_count_reg;
        end
        if (keep_load) begin
            m_speed_reg     <= held_speed_reg;
            m_refreshed_reg <= 1'b0;
        end else if (meas_load) begin
            m_speed_reg     <= sat_speed;
            m_refreshed_reg <= 1'b1;
        end
    end

    awse_mul #(
        .A_WIDTH (POS_WIDTH),
        .B_WIDTH (RATE_W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mag),
        .op_b    (rate_reg),
        .done    (mul_done),
        .product (product)
    );

    awse_div #(
        .DVD_WIDTH (PROD_W),
        .DVS_WIDTH (COUNT_WIDTH)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (product),
        .divisor  (div_count_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign m_valid     = m_valid_reg;
    assign m_speed     = m_speed_reg;
    assign m_refreshed = m_refreshed_reg;

`ifndef SYNTHESIS
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_count_reg != '0)
        else $error("tick count reached zero");

    a_fire_restarts_window: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |=> (tick_count_reg == COUNT_WIDTH'(1)) && (state_reg == ST_MUL))
        else $error("measurement did not restart the window");

    a_mul_done_in_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> state_reg == ST_MUL)
        else $error("multiplier finished outside its state");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside its state");

    a_meas_sets_held: assert property (@(posedge aclk) disable iff (!aresetn)
        meas_load |=> m_refreshed_reg && (m_speed_reg == held_speed_reg))
        else $error("measured speed not held");
`endif

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the adaptive window speed estimator.
`timescale 1ns / 100ps

module testbench;
    import awse_pkg::*;

    localparam int unsigned POS_W   = POS_W_DEF;
    localparam int unsigned CNT_W   = COUNT_W_DEF;
    localparam int unsigned LIMIT   = 1_000_000;
    localparam int unsigned SETTLE  = 80;
    localparam int unsigned PHASES  = 12;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic                      refreshed;
    } speed_result_t;

    logic                        aclk        = 1'b0;
    logic                        aresetn     = 1'b0;
    logic                        cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index   = '0;
    logic [CFG_W-1:0]            cfg_wdata   = '0;
    logic                        s_valid     = 1'b0;
    logic                        s_ready;
    logic signed [IN_W-1:0]      s_position  = '0;
    logic                        m_valid;
    logic                        m_ready     = 1'b0;
    logic signed [SPEED_W-1:0]   m_speed;
    logic                        m_refreshed;

    speed_result_t               expected_speeds[$];
    int                          errors      = 0;
    int unsigned                 cycles      = 0;
    int                          burst_left  = 0;
    int unsigned                 stall_pct   = 0;
    int unsigned                 rx_tick     = 0;

    logic [CFG_W-1:0]            thr_reg;
    logic [CFG_W-1:0]            win_reg;
    logic [CFG_W-1:0]            rate_reg;
    logic [POS_W-1:0]            ref_pos;
    logic [CNT_W-1:0]            win_count;
    logic [SPEED_W-1:0]          held_speed;

    adaptive_window_speed_estimator_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_position  (s_position),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_speed     (m_speed),
        .m_refreshed (m_refreshed)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 256 == 0) begin
            case ($urandom_range(0, 4))
                0, 1: stall_pct <= 0;
                2:    stall_pct <= 30;
                3:    stall_pct <= 60;
                default: stall_pct <= 90;
            endcase
        end
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin : check_result
        speed_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_speeds.size() == 0) begin
                $display("%0t: unexpected transfer, speed %0d refreshed %0b",
                         $time, m_speed, m_refreshed);
                errors++;
            end else begin
                want = expected_speeds.pop_front();
                if (m_speed !== want.speed) begin
                    $display("%0t: speed mismatch, expected %0d, actual %0d",
                             $time, want.speed, m_speed);
                    errors++;
                end
                if (m_refreshed !== want.refreshed) begin
                    $display("%0t: refreshed mismatch, expected %0b, actual %0b",
                             $time, want.refreshed, m_refreshed);
                    errors++;
                end
            end
        end
    end

    function automatic speed_result_t estimate_speed(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] delta;
        logic [POS_W-1:0] mag;
        logic             neg;
        logic [CNT_W:0]   next_count;
        logic [63:0]      quo;
        logic             fire;
        speed_result_t    res;
        delta      = pos - ref_pos;
        neg        = delta[POS_W-1];
        mag        = neg ? -delta : delta;
        next_count = {1'b0, win_count} + 1'b1;
        fire = (64'(mag) > 64'(thr_reg)) || next_count[CNT_W]
            || (next_count > (CNT_W+1)'(win_reg));
        if (fire) begin
            quo = (64'(mag) * 64'(rate_reg)) / 64'(win_count);
            if (!neg)
                held_speed = (quo > 64'(SPEED_POS_MAX)) ? SPEED_POS_MAX : quo[SPEED_W-1:0];
            else
                held_speed = (quo > 64'(SPEED_NEG_MAX)) ? SPEED_NEG_MAX : -quo[SPEED_W-1:0];
            win_count = CNT_W'(1);
            ref_pos   = pos;
        end else begin
            win_count = next_count[CNT_W-1:0];
        end
        res.speed     = held_speed;
        res.refreshed = fire;
        return res;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MOVE_THRESHOLD: thr_reg  = data;
            REG_WINDOW_LIMIT:   win_reg  = data;
            REG_TICK_RATE:      rate_reg = data;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] win,
                             input logic [CFG_W-1:0] rate);
        write_reg(REG_MOVE_THRESHOLD, thr);
        write_reg(REG_WINDOW_LIMIT, win);
        write_reg(REG_TICK_RATE, rate);
    endtask

    task automatic send_position(input logic [POS_W-1:0] pos);
        int gap;
        int pick;
        s_valid    <= 1'b1;
        s_position <= pos;
        do @(posedge aclk); while (!s_ready);
        expected_speeds.push_back(estimate_speed(pos));
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            pick = $urandom_range(0, 9);
            if (pick < 3)
                gap = 0;
            else if (pick < 8)
                gap = $urandom_range(1, 4);
            else
                gap = $urandom_range(8, 30);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_for_results();
        if (s_valid)
            s_valid <= 1'b0;
        while (expected_speeds.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic apply_reset();
        thr_reg    = MOVE_THRESHOLD_RST;
        win_reg    = WINDOW_LIMIT_RST;
        rate_reg   = TICK_RATE_RST;
        ref_pos    = '0;
        win_count  = CNT_W'(1);
        held_speed = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
    endtask

    task automatic test_default_registers();
        send_position(32'h0000_0000);
        send_position(32'h0000_0051);
        send_position(32'hFFFF_FFAF);
        send_position(32'h0000_0052);
        send_position(32'h7FFF_FFFF);
        send_position(32'h8000_0000);
        send_position(32'h0000_0000);
        send_position(32'h8000_0000);
        wait_for_results();
    endtask

    task automatic test_register_extremes();
        configure(16'h0000, 16'h0000, 16'h0000);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_position(32'h0000_0005);
        send_position(32'h0000_0005);
        send_position(32'h8000_0000);
        wait_for_results();
        configure(16'hFFFF, 16'h0001, 16'hFFFF);
        send_position(32'h8000_0000);
        send_position(32'h8001_0000);
        send_position(32'h8000_FFFF);
        wait_for_results();
    endtask

    task automatic test_forced_window();
        configure(16'hFFFF, 16'd5, 16'd1000);
        for (int i = 0; i < 8; i++)
            send_position(32'(i * 100));
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0]  thr;
        logic [CFG_W-1:0]  win;
        logic [CFG_W-1:0]  rate;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  step;
        logic [POS_W-1:0]  reach;
        bit                noisy;
        int                n;
        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 4))
                0:       thr = 16'h0000;
                1:       thr = 16'hFFFF;
                2, 3:    thr = CFG_W'($urandom_range(1, 400));
                default: thr = CFG_W'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 4))
                0:       win = 16'h0000;
                1:       win = 16'h0001;
                2:       win = 16'hFFFF;
                default: win = CFG_W'($urandom_range(2, 300));
            endcase
            case ($urandom_range(0, 4))
                0:       rate = 16'h0000;
                1:       rate = 16'h0001;
                2:       rate = 16'hFFFF;
                default: rate = CFG_W'($urandom_range(1, 65535));
            endcase
            configure(thr, win, rate);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNUSED, CFG_W'($urandom));
            noisy = ($urandom_range(0, 5) == 0);
            reach = 2 * POS_W'(thr) + 16;
            pos   = $urandom;
            n     = $urandom_range(130, 150);
            for (int i = 0; i < n; i++) begin
                if (noisy || $urandom_range(0, 19) == 0) begin
                    pos = $urandom;
                end else begin
                    step = $urandom_range(0, reach);
                    pos  = $urandom_range(0, 1) ? pos + step : pos - step;
                end
                send_position(pos);
                if (ph == PHASES / 2 && i == n / 2)
                    wait_for_results();
            end
            wait_for_results();
        end
    endtask

    initial begin
        apply_reset();
        test_default_registers();
        test_register_extremes();
        test_forced_window();
        test_random_traffic();
        wait_for_results();
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

@@ files.f @@
src/awse_pkg.sv
src/awse_mul.sv
src/awse_div.sv
src/adaptive_window_speed_estimator_unit.sv
test/testbench.sv
